### hw/rtl/nlms_pkg.sv
// Shared types, codes, widths and helpers of the NLMS linear predictor.
package nlms_pkg;

  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_FEATURE = 2'd0;
  localparam cmd_t CMD_TARGET  = 2'd1;
  localparam cmd_t CMD_REINIT  = 2'd2;

  typedef logic [1:0] reg_idx_t;

  localparam reg_idx_t REG_FEATURES_USED = 2'd0;
  localparam reg_idx_t REG_OUTPUTS_USED  = 2'd1;
  localparam reg_idx_t REG_OFFSET_INPUT  = 2'd2;
  localparam reg_idx_t REG_LEARN_RATE    = 2'd3;

  // Dividend of the correction: eta * |error| * 4096.
  localparam int NUM_W  = 60;
  localparam int NORM_W = 40;
  // Correction, clamped to +-2^40, plus sign.
  localparam int CORR_W = 42;
  localparam int PROD_W = CORR_W + 16;
  localparam int CNT_W  = $clog2(NUM_W);

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/nlms_linear_predictor_unit.sv
// Top level of the NLMS linear predictor: sequencer, weight store and shared multiplier.
//
//   channel  direction  handshake          payload
//   in       request in in_valid/in_stall  command, feature_value, target_value
//   out      result out out_valid/out_stall prediction, output_index, last_of_run
//   cfg      write in   cfg_we             cfg_index, cfg_wdata
//
// A feature is stored while idle; the last one of a run then sums L+1 products per output,
// L being the run length, all through the one shared multiplier and weight memory port.
// A target runs the serial divider, one bit a cycle, and then updates L+1 weights.
// Synchronous active-low reset; weights come out of reset as the offset weight pattern.
// in_stall is high while a request is being worked on; an unaccepted result holds the unit.
module nlms_linear_predictor_unit #(
  parameter int MAX_FEATURES = 16,
  parameter int MAX_OUTPUTS  = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic signed [15:0] in_feature_value,
  input  logic signed [31:0] in_target_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_prediction,
  output logic [1:0]         out_output_index,
  output logic               out_last_of_run,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  localparam int ROW_LEN = MAX_FEATURES + 1;
  localparam int WDEPTH  = ROW_LEN * MAX_OUTPUTS;
  localparam int AW      = $clog2(WDEPTH);
  localparam int KW      = $clog2(MAX_FEATURES + 1);
  localparam int OW      = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int TW      = $clog2(MAX_OUTPUTS + 1);
  localparam int ACC_W   = nlms_pkg::PROD_W + 8;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ERR  = 4'd1;
  localparam logic [3:0] S_MAG  = 4'd2;
  localparam logic [3:0] S_DST  = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_RD   = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_ACC  = 4'd7;
  localparam logic [3:0] S_RND  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  // Configuration registers
  logic [4:0]         features_used_r;
  logic [2:0]         outputs_used_r;
  logic signed [15:0] offset_input_r;
  logic [15:0]        learn_rate_r;

  // Sequencer state
  logic [3:0]              state_r;
  logic                    upd_r;
  logic [KW-1:0]           fcnt_r;
  logic [TW-1:0]           tcnt_r;
  logic [KW-1:0]           run_len_r;
  logic [TW-1:0]           run_outs_r;
  logic [OW-1:0]           o_r;
  logic [KW-1:0]           k_r;
  logic [nlms_pkg::NORM_W-1:0] norm_r;
  logic signed [15:0]      init_x0_r;
  logic [WDEPTH-1:0]       wvld_r;
  logic signed [31:0]      lp_r [MAX_OUTPUTS];
  logic                    out_valid_r;

  // Datapath registers
  logic signed [15:0]          ibuf [ROW_LEN];
  logic signed [31:0]          wmem [WDEPTH];
  logic signed [31:0]          rd_data_r;
  logic                        rd_vld_r;
  logic signed [31:0]          wcur_r;
  logic signed [31:0]          tgt_r;
  logic signed [32:0]          err_r;
  logic                        neg_r;
  logic [47:0]                 mag_r;
  logic signed [nlms_pkg::CORR_W-1:0] corr_r;
  logic signed [nlms_pkg::PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]     acc_r;
  logic signed [31:0]          pred_r;

  logic                        in_acc;
  logic [KW-1:0]               fe;
  logic [TW-1:0]               eo;
  logic [KW-1:0]               fcnt_inc;
  logic [AW-1:0]               addr;
  logic signed [31:0]          wval;
  logic signed [nlms_pkg::CORR_W-1:0] op_a;
  logic signed [nlms_pkg::PROD_W-1:0] dsh;
  logic signed [31:0]          new_w;
  logic signed [ACC_W-1:0]     rnd;
  logic [nlms_pkg::NUM_W-1:0]  quotient;
  logic [nlms_pkg::CORR_W-2:0] qmag;
  nlms_pkg::div_stat_t         div_stat;
  logic                        div_start;
  logic signed [31:0]          x0sq;
  logic signed [31:0]          fsq;
  logic [32:0]                 err_abs;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign div_start = (state_r == S_DST);

  always_comb begin
    if (features_used_r == 5'd0) begin
      fe = KW'(1);
    end else if (int'(features_used_r) > MAX_FEATURES) begin
      fe = KW'(MAX_FEATURES);
    end else begin
      fe = KW'(features_used_r);
    end
    if (outputs_used_r == 3'd0) begin
      eo = TW'(1);
    end else if (int'(outputs_used_r) > MAX_OUTPUTS) begin
      eo = TW'(MAX_OUTPUTS);
    end else begin
      eo = TW'(outputs_used_r);
    end
  end

  assign fcnt_inc = fcnt_r + 1'b1;
  assign addr     = AW'(int'(o_r) * ROW_LEN + int'(k_r));
  assign x0sq     = offset_input_r * offset_input_r;
  assign fsq      = in_feature_value * in_feature_value;
  assign err_abs  = err_r[32] ? 33'(-err_r) : 33'(err_r);

  // An entry not written since reset or reinit holds the offset pattern.
  always_comb begin
    if (rd_vld_r) begin
      wval = rd_data_r;
    end else if (k_r == '0) begin
      wval = 32'(init_x0_r) <<< 12;
    end else begin
      wval = '0;
    end
  end

  assign op_a  = upd_r ? corr_r : nlms_pkg::CORR_W'(wval);
  assign dsh   = (prod_r + nlms_pkg::PROD_W'(128)) >>> 8;
  assign new_w = nlms_pkg::sat32(64'(wcur_r) + 64'(dsh));
  assign rnd   = (acc_r + ACC_W'(1 << 19)) >>> 20;

  // Clamp the quotient magnitude to 2^40.
  always_comb begin
    if (quotient > nlms_pkg::NUM_W'(64'd1 << 40)) begin
      qmag = (nlms_pkg::CORR_W - 1)'(64'd1 << 40);
    end else begin
      qmag = quotient[nlms_pkg::CORR_W-2:0];
    end
  end

  nlms_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({mag_r, 12'd0}),
    .divisor  (norm_r),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // Weight memory with registered read.
  always_ff @(posedge clk) begin
    if (state_r == S_ACC && upd_r) begin
      wmem[addr] <= new_w;
    end
    rd_data_r <= wmem[addr];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_command == nlms_pkg::CMD_FEATURE) begin
      if (fcnt_r == '0) begin
        ibuf[0] <= offset_input_r;
      end
      ibuf[fcnt_inc] <= in_feature_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      features_used_r <= 5'd16;
      outputs_used_r  <= 3'd1;
      offset_input_r  <= 16'sd4096;
      learn_rate_r    <= 16'd6554;
      state_r         <= S_IDLE;
      upd_r           <= 1'b0;
      fcnt_r          <= '0;
      tcnt_r          <= '0;
      run_len_r       <= '0;
      run_outs_r      <= '0;
      o_r             <= '0;
      k_r             <= '0;
      norm_r          <= '0;
      init_x0_r       <= 16'sd4096;
      wvld_r          <= '0;
      rd_vld_r        <= 1'b0;
      out_valid_r     <= 1'b0;
      for (int i = 0; i < MAX_OUTPUTS; i++) begin
        lp_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          nlms_pkg::REG_FEATURES_USED: features_used_r <= cfg_wdata[4:0];
          nlms_pkg::REG_OUTPUTS_USED:  outputs_used_r  <= cfg_wdata[2:0];
          nlms_pkg::REG_OFFSET_INPUT:  offset_input_r  <= cfg_wdata;
          nlms_pkg::REG_LEARN_RATE:    learn_rate_r    <= cfg_wdata;
          default: ;
        endcase
      end
      rd_vld_r <= wvld_r[addr];
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_command)
              nlms_pkg::CMD_FEATURE: begin
                norm_r <= ((fcnt_r == '0) ? nlms_pkg::NORM_W'($unsigned(x0sq)) : norm_r)
                          + nlms_pkg::NORM_W'($unsigned(fsq));
                if (fcnt_inc >= fe) begin
                  run_len_r  <= fcnt_inc;
                  run_outs_r <= eo;
                  fcnt_r     <= '0;
                  tcnt_r     <= '0;
                  o_r        <= '0;
                  k_r        <= '0;
                  upd_r      <= 1'b0;
                  state_r    <= S_RD;
                end else begin
                  fcnt_r <= fcnt_inc;
                end
              end
              nlms_pkg::CMD_TARGET: begin
                if (fcnt_r == '0 && tcnt_r < run_outs_r) begin
                  if (norm_r == '0) begin
                    tcnt_r <= tcnt_r + 1'b1;
                  end else begin
                    o_r     <= OW'(tcnt_r);
                    upd_r   <= 1'b1;
                    state_r <= S_ERR;
                  end
                end
              end
              nlms_pkg::CMD_REINIT: begin
                wvld_r    <= '0;
                init_x0_r <= offset_input_r;
              end
              default: ;
            endcase
          end
        end
        S_ERR: begin
          state_r <= S_MAG;
        end
        S_MAG: begin
          state_r <= S_DST;
        end
        S_DST: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            k_r     <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (upd_r) begin
            wvld_r[addr] <= 1'b1;
          end
          if (k_r == run_len_r) begin
            if (upd_r) begin
              tcnt_r  <= tcnt_r + 1'b1;
              state_r <= S_IDLE;
            end else begin
              state_r <= S_RND;
            end
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_RND: begin
          lp_r[o_r]   <= nlms_pkg::sat32(64'(rnd));
          out_valid_r <= 1'b1;
          state_r     <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (TW'(o_r) + 1'b1 == run_outs_r) begin
              state_r <= S_IDLE;
            end else begin
              o_r     <= o_r + 1'b1;
              k_r     <= '0;
              state_r <= S_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      tgt_r <= in_target_value;
    end
    if (state_r == S_RD && k_r == '0) begin
      acc_r <= '0;
    end else if (state_r == S_ACC && !upd_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (state_r == S_ERR) begin
      err_r <= 33'(tgt_r) - 33'(lp_r[o_r]);
    end
    if (state_r == S_MAG) begin
      neg_r <= err_r[32];
      mag_r <= 48'(learn_rate_r) * 48'(err_abs);
    end
    if (state_r == S_DIV && div_stat.done) begin
      corr_r <= neg_r ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    end
    if (state_r == S_MUL) begin
      prod_r <= op_a * ibuf[k_r];
      wcur_r <= wval;
    end
    if (state_r == S_RND) begin
      pred_r <= nlms_pkg::sat32(64'(rnd));
    end
  end

  assign out_prediction   = pred_r;
  assign out_output_index = 2'(o_r);
  assign out_last_of_run  = (TW'(o_r) + 1'b1 == run_outs_r);

endmodule

### hw/rtl/nlms_div.sv
// Restoring serial divider: one quotient bit per cycle.
module nlms_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [nlms_pkg::NUM_W-1:0]     dividend,
  input  logic [nlms_pkg::NORM_W-1:0]    divisor,
  output logic [nlms_pkg::NUM_W-1:0]     quotient,
  output nlms_pkg::div_stat_t            stat
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [nlms_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [nlms_pkg::NORM_W:0]     rem_r, rem_nxt;
  logic [nlms_pkg::NUM_W-1:0]    quo_r, quo_nxt;
  logic [nlms_pkg::NORM_W-1:0]   dvs_r, dvs_nxt;
  logic [nlms_pkg::NORM_W:0]     trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r[nlms_pkg::NORM_W-1:0], quo_r[nlms_pkg::NUM_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = nlms_pkg::CNT_W'(nlms_pkg::NUM_W - 1);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[nlms_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[nlms_pkg::NUM_W-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

### sim/tb_nlms_linear_predictor_unit.sv
// Self-checking testbench of the NLMS linear predictor unit with its own prediction model.
module tb_nlms_linear_predictor_unit;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXF = 16;
  localparam int MAXO = 4;
  localparam int ROWL = MAXF + 1;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE = 400;
  localparam int HOLD_LEN = 700;

  // Command code that the unit ignores.
  localparam nlms_pkg::cmd_t CMD_UNUSED = 2'd3;

  typedef struct {
    nlms_pkg::cmd_t     cmd;
    logic signed [15:0] feat;
    logic signed [31:0] tgt;
  } request_t;

  typedef struct {
    logic signed [31:0] pred;
    logic [1:0]         idx;
    logic               last;
  } prediction_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_command;
  logic signed [15:0] in_feature_value;
  logic signed [31:0] in_target_value;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_prediction;
  logic [1:0]         out_output_index;
  logic               out_last_of_run;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_wdata;

  request_t    pending_q[$];
  prediction_t predicted_q[$];
  int          send_idle_pct;
  int          recv_stall_pct;
  int          phase_no;
  int          errors = 0;
  int          hold_left;
  logic        held;
  longint      cycles = 0;

  // Shadow copies of the configuration registers.
  logic [4:0]         m_features = 5'd16;
  logic [2:0]         m_outputs = 3'd1;
  logic signed [15:0] m_offset = 16'sd4096;
  logic [15:0]        m_eta = 16'd6554;

  // Shadow state of the unit.
  logic signed [15:0] m_inbuf[ROWL];
  logic signed [31:0] m_weight[MAXO][ROWL];
  logic signed [31:0] m_lastp[MAXO];
  longint             m_norm;
  int                 m_fcnt, m_tcnt, m_rlen, m_routs;

  nlms_linear_predictor_unit DUT (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic signed [31:0] clip32(longint v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  task automatic reset_weights();
    for (int o = 0; o < MAXO; o++) begin
      for (int k = 0; k < ROWL; k++) m_weight[o][k] = '0;
      m_weight[o][0] = 32'(longint'(m_offset) * 4096);
    end
  endtask

  task automatic reset_model();
    m_norm = 0;
    m_fcnt = 0;
    m_tcnt = 0;
    m_rlen = 0;
    m_routs = 0;
    for (int o = 0; o < MAXO; o++) m_lastp[o] = '0;
    for (int k = 0; k < ROWL; k++) m_inbuf[k] = '0;
    reset_weights();
  endtask

  task automatic apply_request(request_t r);
    longint      f, acc, err, num, corr, d;
    int          fe, eo;
    prediction_t e;
    if (r.cmd == nlms_pkg::CMD_FEATURE) begin
      f  = longint'(r.feat);
      fe = (m_features < 1) ? 1 : (m_features > MAXF) ? MAXF : m_features;
      eo = (m_outputs < 1) ? 1 : (m_outputs > MAXO) ? MAXO : m_outputs;
      if (m_fcnt == 0) begin
        m_inbuf[0] = m_offset;
        m_norm = longint'(m_offset) * longint'(m_offset);
      end
      m_inbuf[1 + m_fcnt] = r.feat;
      m_norm += f * f;
      m_fcnt++;
      if (m_fcnt >= fe) begin
        m_rlen = m_fcnt;
        m_routs = eo;
        m_fcnt = 0;
        m_tcnt = 0;
        for (int o = 0; o < m_routs; o++) begin
          acc = 0;
          for (int k = 0; k <= m_rlen; k++)
            acc += longint'(m_weight[o][k]) * longint'(m_inbuf[k]);
          m_lastp[o] = clip32((acc + (64'sd1 <<< 19)) >>> 20);
          e.pred = m_lastp[o];
          e.idx  = 2'(o);
          e.last = (o + 1 == m_routs);
          predicted_q.push_back(e);
        end
      end
    end else if (r.cmd == nlms_pkg::CMD_TARGET) begin
      if (m_fcnt == 0 && m_tcnt < m_routs) begin
        // A zero norm leaves the weights alone but still consumes the target.
        if (m_norm != 0) begin
          err  = longint'(r.tgt) - longint'(m_lastp[m_tcnt]);
          num  = longint'(m_eta) * err * 4096;
          corr = num / m_norm;
          if (corr > (64'sd1 <<< 40)) corr = 64'sd1 <<< 40;
          if (corr < -(64'sd1 <<< 40)) corr = -(64'sd1 <<< 40);
          for (int k = 0; k <= m_rlen; k++) begin
            d = (corr * longint'(m_inbuf[k]) + 128) >>> 8;
            m_weight[m_tcnt][k] = clip32(longint'(m_weight[m_tcnt][k]) + d);
          end
        end
        m_tcnt++;
      end
    end else if (r.cmd == nlms_pkg::CMD_REINIT) begin
      reset_weights();
    end
  endtask

  // Request driver.
  always @(posedge clk) begin
    request_t r;
    if (!rst_n) begin
      in_valid         <= 1'b0;
      in_command       <= '0;
      in_feature_value <= '0;
      in_target_value  <= '0;
      reset_model();
    end else begin
      if (in_valid && !in_stall)
        apply_request('{cmd: in_command, feat: in_feature_value, tgt: in_target_value});
      if (!in_valid || !in_stall) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          r = pending_q.pop_front();
          in_command       <= r.cmd;
          in_feature_value <= r.feat;
          in_target_value  <= r.tgt;
          in_valid         <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk) begin
    prediction_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      held      <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_q.size() == 0) begin
          $error("unexpected result: prediction %0d index %0d", out_prediction,
                 out_output_index);
          errors++;
        end else begin
          e = predicted_q.pop_front();
          if (out_prediction !== e.pred) begin
            $error("prediction: expected %0d, got %0d", e.pred, out_prediction);
            errors++;
          end
          if (out_output_index !== e.idx) begin
            $error("output_index: expected %0d, got %0d", e.idx, out_output_index);
            errors++;
          end
          if (out_last_of_run !== e.last) begin
            $error("last_of_run: expected %0d, got %0d", e.last, out_last_of_run);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (phase_no == 0 && !held && out_valid) begin
        // Long hold-off so that the unit holds its result and stalls its requests.
        out_stall <= 1'b1;
        hold_left <= HOLD_LEN;
        held      <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(nlms_pkg::reg_idx_t idx, logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      nlms_pkg::REG_FEATURES_USED: m_features = v[4:0];
      nlms_pkg::REG_OUTPUTS_USED:  m_outputs  = v[2:0];
      nlms_pkg::REG_OFFSET_INPUT:  m_offset   = v;
      nlms_pkg::REG_LEARN_RATE:    m_eta      = v;
      default: ;
    endcase
  endtask

  task automatic configure(logic [15:0] fu, logic [15:0] ou, logic [15:0] off,
                           logic [15:0] eta);
    write_reg(nlms_pkg::REG_FEATURES_USED, fu);
    write_reg(nlms_pkg::REG_OUTPUTS_USED, ou);
    write_reg(nlms_pkg::REG_OFFSET_INPUT, off);
    write_reg(nlms_pkg::REG_LEARN_RATE, eta);
  endtask

  task automatic push(nlms_pkg::cmd_t c, logic signed [15:0] f, logic signed [31:0] t);
    pending_q.push_back('{cmd: c, feat: f, tgt: t});
  endtask

  function automatic logic signed [15:0] rand_feature();
    if ($urandom_range(7) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(4096)) - 2048);
  endfunction

  function automatic logic signed [31:0] rand_target();
    if ($urandom_range(5) == 0) return 32'($urandom);
    return 32'($signed($urandom_range(1 << 21)) - (1 << 20));
  endfunction

  task automatic run_phase();
    while (pending_q.size() > 0 || in_valid || predicted_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    int cnt, fe, eo, r;
    cnt = 0;
    while (cnt < n) begin
      r  = $urandom_range(99);
      fe = (m_features < 1) ? 1 : (m_features > MAXF) ? MAXF : m_features;
      eo = (m_outputs < 1) ? 1 : (m_outputs > MAXO) ? MAXO : m_outputs;
      if (r < 75) begin
        for (int i = 0; i < fe; i++) push(nlms_pkg::CMD_FEATURE, rand_feature(), '0);
        for (int i = 0; i < eo; i++) push(nlms_pkg::CMD_TARGET, '0, rand_target());
        cnt += fe + eo;
      end else begin
        if (r < 85) push(nlms_pkg::CMD_FEATURE, rand_feature(), '0);
        else if (r < 90) push(CMD_UNUSED, rand_feature(), rand_target());
        else if (r < 94) push(nlms_pkg::CMD_REINIT, '0, '0);
        else push(nlms_pkg::CMD_TARGET, '0, rand_target());
        cnt++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    phase_no = -1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extreme values, an out-of-range output count, stray targets and the unused command.
    configure(16'd2, 16'd7, 16'h7fff, 16'hffff);
    phase_no = 0;
    push(nlms_pkg::CMD_TARGET, '0, 32'sd1000);
    push(nlms_pkg::CMD_FEATURE, 16'sh8000, '0);
    push(nlms_pkg::CMD_TARGET, '0, 32'sd5);
    push(nlms_pkg::CMD_FEATURE, 16'sh7fff, '0);
    push(nlms_pkg::CMD_TARGET, '0, 32'sh7fffffff);
    push(nlms_pkg::CMD_TARGET, '0, 32'sh80000000);
    push(nlms_pkg::CMD_TARGET, '0, '0);
    push(nlms_pkg::CMD_TARGET, '0, 32'sh00010000);
    push(nlms_pkg::CMD_TARGET, '0, 32'sd77);
    push(CMD_UNUSED, 16'shffff, 32'shffffffff);
    push(nlms_pkg::CMD_FEATURE, 16'sd0, '0);
    push(nlms_pkg::CMD_FEATURE, 16'sd1, '0);
    push(nlms_pkg::CMD_FEATURE, 16'sd100, '0);
    push(nlms_pkg::CMD_REINIT, '0, '0);
    push(nlms_pkg::CMD_FEATURE, 16'sh8000, '0);
    push(nlms_pkg::CMD_FEATURE, 16'sh8000, '0);
    run_phase();

    // Zero norm skips the update; lowest counts clamp up to one.
    configure(16'd0, 16'd0, 16'h0000, 16'd0);
    phase_no = 1;
    push(nlms_pkg::CMD_REINIT, '0, '0);
    push(nlms_pkg::CMD_FEATURE, 16'sd0, '0);
    push(nlms_pkg::CMD_TARGET, '0, 32'sd12345);
    push(nlms_pkg::CMD_FEATURE, 16'sd0, '0);
    push(nlms_pkg::CMD_FEATURE, 16'sd300, '0);
    run_phase();

    // Leave a run half done, then lower the feature count below it.
    configure(16'd31, 16'd4, 16'h8000, 16'd6554);
    phase_no = 2;
    for (int i = 0; i < 5; i++) push(nlms_pkg::CMD_FEATURE, rand_feature(), '0);
    run_phase();
    write_reg(nlms_pkg::REG_FEATURES_USED, 16'd3);

    for (int p = 3; p < 10; p++) begin
      phase_no = p;
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      random_phase(24);
      run_phase();
      if ($urandom_range(2) == 0) begin
        configure(16'($urandom_range(0, 31)), 16'($urandom_range(0, 7)), 16'($urandom),
                  16'($urandom));
      end else begin
        // Mostly small runs keep the unit quick.
        configure(16'($urandom_range(1, 5)), 16'($urandom_range(1, 4)),
                  16'($signed($urandom_range(8192)) - 4096), 16'($urandom_range(65535)));
      end
      if ($urandom_range(3) == 0) push(nlms_pkg::CMD_REINIT, '0, '0);
    end
    phase_no = 10;
    random_phase(16);
    run_phase();

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/nlms_pkg.sv
hw/rtl/nlms_div.sv
hw/rtl/nlms_linear_predictor_unit.sv
sim/tb_nlms_linear_predictor_unit.sv
